@@ hw/rtl/msb_first_bit_reader_core_macros.svh @@
// Assertion macros shared by the RTL. Both sample on clk_i and stay quiet in reset.
`ifndef MSB_FIRST_BIT_READER_CORE_MACROS_SVH
`define MSB_FIRST_BIT_READER_CORE_MACROS_SVH

// Same-cycle implication.
`define MSBBR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MSBBR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/msbbr_pkg.sv @@
package msbbr_pkg;

  typedef enum logic [2:0] {
    OP_PUSH       = 3'd0,
    OP_READ       = 3'd1,
    OP_PEEK       = 3'd2,
    OP_SKIP       = 3'd3,
    OP_ALIGN_READ = 3'd4,
    OP_BYTE_SKIP  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD_SIZE = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  byte_in;
    logic [31:0] bit_count;
    logic [31:0] byte_count;
    logic        little_endian;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
    logic [6:0]  bits_available;
  } out_item_t;

endpackage

@@ hw/rtl/msbbr_chan_if.sv @@
interface msbbr_chan_if import msbbr_pkg::*; #(
  parameter type payload_t = in_item_t
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/msb_first_bit_reader_core.sv @@
// MSB-first bitstream reader. Each request transaction on in_i (push a byte, read, peek or
// skip bits, byte-aligned read of 1..8 bytes, or byte skip) yields exactly one result
// transaction on out_o with the value, a status and the bits held afterwards. A request
// is registered, then resolved by barrel shifts of the WINDOW_BITS window that update
// the window, its fill count and the pending-skip count at the same edge as the result
// register. One request is taken every cycle unless out_o stalls; a request waits in
// item_q and its result in res_q, and out_o stalls hold both stages without loss.
`include "msb_first_bit_reader_core_macros.svh"

module msb_first_bit_reader_core import msbbr_pkg::*; #(
  parameter int WINDOW_BITS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  msbbr_chan_if.sink   in_i,
  msbbr_chan_if.source out_o
);

  localparam int HELD_W     = $clog2(WINDOW_BITS + 1);
  localparam int PUSH_LIMIT = WINDOW_BITS - 8;
  localparam int MAX_BYTES  = (WINDOW_BITS / 8 < 8) ? WINDOW_BITS / 8 : 8;
  localparam logic [HELD_W-1:0] WIN_H  = HELD_W'(WINDOW_BITS);
  localparam logic [HELD_W-1:0] PUSH_H = HELD_W'(PUSH_LIMIT);

  logic [WINDOW_BITS-1:0] window_q, window_d;
  logic [HELD_W-1:0]      held_q, held_d;
  logic [31:0]            pend_q, pend_d;

  in_item_t  item_q;
  logic      item_vld_q;
  out_item_t res_q, res_d;
  logic      res_vld_q;
  logic      res_free, fire;

  assign res_free    = !res_vld_q || out_o.ready;
  assign fire        = item_vld_q && res_free;
  assign in_i.ready  = !item_vld_q || fire;
  assign out_o.valid = res_vld_q;
  assign out_o.data  = res_q;

  logic [31:0]            nb, bc, held32, from32, rest;
  logic [HELD_W-1:0]      nb_h, rem_h, held_al, abits_h, avail, from_h, bs_drop;
  logic [WINDOW_BITS-1:0] peek_v, w_al, ar_v, kept_w;
  logic [63:0]            ar64, swp;
  logic [32:0]            skip_tot, pend_r;
  logic [35:0]            bs_tot;
  logic [7:0]             kept;
  logic [2:0]             sh;

  always_comb begin
    nb      = item_q.bit_count;
    bc      = item_q.byte_count;
    held32  = 32'(held_q);
    nb_h    = nb[HELD_W-1:0];
    rem_h   = HELD_W'(held_q[2:0]);
    held_al = held_q - rem_h;
    peek_v  = window_q >> (WIN_H - nb_h);

    abits_h = HELD_W'({bc[3:0], 3'b000});
    w_al    = window_q << rem_h;
    ar_v    = w_al >> (WIN_H - abits_h);
    ar64    = 64'(ar_v);
    swp     = '0;
    for (int i = 0; i < 8; i++) begin
      sh = 3'(bc[3:0] - 4'd1 - 4'(i));
      if (4'(i) < bc[3:0]) begin
        swp[8*i +: 8] = ar64[{sh, 3'b000} +: 8];
      end
    end

    skip_tot = {1'b0, pend_q} + {1'b0, nb - held32};

    avail   = held_q >> 3;
    from32  = (bc < 32'(avail)) ? bc : 32'(avail);
    rest    = bc - from32;
    pend_r  = (pend_q == '0) ? 33'd0 : (({1'b0, pend_q} + 33'd7) & ~33'd7);
    bs_tot  = 36'(pend_r) + {1'b0, rest, 3'b000};
    from_h  = HELD_W'({from32[3:0], 3'b000});
    bs_drop = rem_h + from_h;

    kept    = item_q.byte_in << pend_q[2:0];
    kept_w  = WINDOW_BITS'(kept) << (PUSH_H - held_q);

    window_d = window_q;
    held_d   = held_q;
    pend_d   = pend_q;
    res_d.value  = '0;
    res_d.status = ST_OK;

    case (item_q.op)
      OP_PUSH: begin
        if (held_q > PUSH_H) begin
          res_d.status = ST_FULL;
        end else if (pend_q >= 32'd8) begin
          pend_d = pend_q - 32'd8;
        end else begin
          window_d = window_q | kept_w;
          held_d   = held_q + HELD_W'(4'd8 - 4'(pend_q[2:0]));
          pend_d   = '0;
        end
      end
      OP_READ, OP_PEEK: begin
        if (nb > 32'(WINDOW_BITS)) begin
          res_d.status = ST_BAD_SIZE;
        end else if (nb > held32) begin
          res_d.status = ST_SHORT;
        end else begin
          res_d.value = 64'(peek_v);
          if (item_q.op == OP_READ) begin
            window_d = window_q << nb_h;
            held_d   = held_q - nb_h;
          end
        end
      end
      OP_SKIP: begin
        if (nb <= held32) begin
          window_d = window_q << nb_h;
          held_d   = held_q - nb_h;
        end else if (skip_tot[32]) begin
          res_d.status = ST_BAD_SIZE;
        end else begin
          pend_d   = skip_tot[31:0];
          window_d = '0;
          held_d   = '0;
        end
      end
      OP_ALIGN_READ: begin
        if (bc == '0 || bc > 32'(MAX_BYTES)) begin
          res_d.status = ST_BAD_SIZE;
        end else if (pend_q != '0 || abits_h > held_al) begin
          res_d.status = ST_SHORT;
        end else begin
          window_d    = w_al << abits_h;
          held_d      = held_al - abits_h;
          res_d.value = item_q.little_endian ? swp : ar64;
        end
      end
      OP_BYTE_SKIP: begin
        if (bs_tot[35:32] != 4'd0) begin
          res_d.status = ST_BAD_SIZE;
        end else begin
          window_d = window_q << bs_drop;
          held_d   = held_q - bs_drop;
          pend_d   = bs_tot[31:0];
        end
      end
      default: begin
        res_d.status = ST_BAD_SIZE;
      end
    endcase

    res_d.bits_available = 7'(held_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
      window_q   <= '0;
      held_q     <= '0;
      pend_q     <= '0;
    end else begin
      if (in_i.ready) begin
        item_vld_q <= in_i.valid;
      end
      if (res_free) begin
        res_vld_q <= fire;
      end
      if (fire) begin
        window_q <= window_d;
        held_q   <= held_d;
        pend_q   <= pend_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= in_i.data;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  `MSBBR_ASSERT_IMP(a_held_range, 1'b1, held_q <= WIN_H, "fill count above window size")
  `MSBBR_ASSERT_IMP(a_pend_empty, pend_q != '0, held_q == '0 && window_q == '0,
                    "pending skip with bits held")
  `MSBBR_ASSERT_IMP(a_unused_zero, 1'b1, (window_q << held_q) == '0,
                    "bits below the fill count not zero")
  `MSBBR_ASSERT_IMP(a_err_value, res_vld_q && res_q.status != ST_OK, res_q.value == '0,
                    "nonzero value on error status")
  `MSBBR_ASSERT_NXT(a_err_hold, fire && res_d.status != ST_OK,
                    $stable(window_q) && $stable(held_q) && $stable(pend_q),
                    "state changed on error status")

endmodule
